// ===== src/spq_pkg.sv =====
// Shared constants, codes and controller/datapath handshake types of the priority queue.
package spq_pkg;

  // Queue capacity and the widths that follow from it.
  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Field widths of one transaction.
  localparam int PRIO_W   = 16;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;

  // Operation codes carried by the func field.
  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_REMOVE = 1'b1
  } func_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_REMOVED  = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture the accepted request
    logic exec;   // apply the request to the queue and write the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_busy;  // result register holds a result that is not taken this cycle
  } stat_t;

endpackage

// ===== src/spq_ctrl.sv =====
// Controller state machine of the priority queue: request intake and execute sequencing.
module spq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  spq_pkg::stat_t stat,
  output spq_pkg::cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd.load  = 1'b0;
    cmd.exec  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        // Wait until the result register can take the new result.
        if (!stat.out_busy) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTH
  // An accepted transaction is always followed by its execute cycle.
  a_load_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == S_EXEC))
    else $error("accepted transaction did not enter execute");

  // A blocked result register holds the request in execute.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) && stat.out_busy |=> (state_r == S_EXEC) && !in_ready)
    else $error("request left execute while result register was blocked");

  // The state register always holds exactly one active state.
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("controller state is not one-hot");
`endif

endmodule

// ===== src/spq_datapath.sv =====
// Datapath of the priority queue: sorted entry slots, parallel compare and shift, result register.
module spq_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  spq_pkg::cmd_t                       cmd,
  output spq_pkg::stat_t                      stat,
  input  logic                                in_func,
  input  logic        [spq_pkg::PRIO_W-1:0]   in_priority_req,
  input  logic signed [spq_pkg::DATA_W-1:0]   in_payload,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic        [spq_pkg::STATUS_W-1:0] out_status,
  output logic        [spq_pkg::PRIO_W-1:0]   out_priority,
  output logic signed [spq_pkg::DATA_W-1:0]   out_payload
);

  localparam int N = spq_pkg::QUEUE_DEPTH;

  // Entry slots, slot 0 is the head (lowest priority).
  logic [spq_pkg::PRIO_W-1:0] prio_r [N];
  logic [spq_pkg::DATA_W-1:0] data_r [N];
  logic [spq_pkg::CNT_W-1:0]  fill_r;

  // Captured request.
  logic                       req_func_r;
  logic [spq_pkg::PRIO_W-1:0] req_prio_r;
  logic [spq_pkg::DATA_W-1:0] req_data_r;

  // Result register.
  logic                                out_valid_r;
  logic        [spq_pkg::STATUS_W-1:0] out_status_r;
  logic        [spq_pkg::PRIO_W-1:0]   out_prio_r;
  logic signed [spq_pkg::DATA_W-1:0]   out_data_r;

  logic [N-1:0] le;        // slot holds a live entry not above the request priority
  logic [N-1:0] le_prev;   // same flag of the slot below, true below slot 0
  logic [spq_pkg::PRIO_W-1:0] up_prio [N];
  logic [spq_pkg::DATA_W-1:0] up_data [N];
  logic [spq_pkg::PRIO_W-1:0] dn_prio [N];
  logic [spq_pkg::DATA_W-1:0] dn_data [N];
  logic full;
  logic empty;
  logic do_insert;
  logic do_remove;

  assign full      = (fill_r == spq_pkg::CNT_W'(N));
  assign empty     = (fill_r == '0);
  assign do_insert = cmd.exec && (req_func_r == spq_pkg::FUNC_INSERT) && !full;
  assign do_remove = cmd.exec && (req_func_r == spq_pkg::FUNC_REMOVE) && !empty;

  // Per-slot compare against the request priority.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      le[i] = (spq_pkg::CNT_W'(i) < fill_r) && (prio_r[i] <= req_prio_r);
    end
    le_prev = {le[N-2:0], 1'b1};
  end

  // Neighbor taps for the shift up (insert) and shift down (remove).
  always_comb begin
    up_prio[0] = prio_r[0];
    up_data[0] = data_r[0];
    for (int i = 1; i < N; i++) begin
      up_prio[i] = prio_r[i-1];
      up_data[i] = data_r[i-1];
    end
    for (int i = 0; i < N - 1; i++) begin
      dn_prio[i] = prio_r[i+1];
      dn_data[i] = data_r[i+1];
    end
    dn_prio[N-1] = prio_r[N-1];
    dn_data[N-1] = data_r[N-1];
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_func_r <= in_func;
      req_prio_r <= in_priority_req;
      req_data_r <= in_payload;
    end
  end

  // Slot update: keep, take the new entry, or shift by one.
  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      if (do_insert && !le[i]) begin
        if (le_prev[i]) begin
          prio_r[i] <= req_prio_r;
          data_r[i] <= req_data_r;
        end else begin
          prio_r[i] <= up_prio[i];
          data_r[i] <= up_data[i];
        end
      end else if (do_remove) begin
        prio_r[i] <= dn_prio[i];
        data_r[i] <= dn_data[i];
      end
    end
  end

  // Fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (do_insert) begin
      fill_r <= fill_r + spq_pkg::CNT_W'(1);
    end else if (do_remove) begin
      fill_r <= fill_r - spq_pkg::CNT_W'(1);
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.exec) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_prio_r <= '0;
      out_data_r <= '0;
      if (req_func_r == spq_pkg::FUNC_INSERT) begin
        out_status_r <= full ? spq_pkg::ST_FULL : spq_pkg::ST_INSERTED;
      end else if (empty) begin
        out_status_r <= spq_pkg::ST_EMPTY;
      end else begin
        out_status_r <= spq_pkg::ST_REMOVED;
        out_prio_r   <= prio_r[0];
        out_data_r   <= data_r[0];
      end
    end
  end

  assign stat.out_busy = out_valid_r && !out_ready;
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_priority  = out_prio_r;
  assign out_payload   = out_data_r;

`ifndef SYNTH
  // The fill count never passes the capacity.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= spq_pkg::CNT_W'(N))
    else $error("fill count above capacity");

  // A successful remove takes exactly one entry out.
  a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
    do_remove |=> (fill_r == $past(fill_r) - spq_pkg::CNT_W'(1)))
    else $error("remove did not decrement fill count");

  // A full queue reports a dropped insert.
  a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && (req_func_r == spq_pkg::FUNC_INSERT) && full
      |=> out_valid_r && (out_status_r == spq_pkg::ST_FULL))
    else $error("insert into full queue not flagged");
`endif

endmodule

// ===== src/sorted_insert_priority_queue.sv =====
// Top level of the sorted-insert priority queue: controller and datapath.
//
// Usage: a bounded priority queue of spq_pkg::QUEUE_DEPTH entries kept sorted,
// lowest priority at the head. Each input transaction (valid/ready) is either
// an insert (in_func = 0) of in_priority_req with in_payload, or a remove
// (in_func = 1). Every input transaction yields exactly one result transaction
// on the out_ channel with a status: inserted, full and dropped, removed, or
// empty. A remove returns the head entry; other results carry zero data.
// Equal priorities leave in arrival order.
// Timing: the request is captured at the accepting edge; the result turns
// valid at the end of the execute state, in which all slots compare and shift
// in parallel; execute waits while the result register is blocked.
// Intake: a new transaction is accepted only once the previous one has left
// execute, following the capture/execute sequence of the controller.
// Reset (rst_n low, synchronous) empties the queue and drops any result held.
// When the receiver stalls, the result is held in the output register; one
// further transaction is accepted and waits in execute until that register
// frees up.
module sorted_insert_priority_queue (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_func,
  input  logic        [spq_pkg::PRIO_W-1:0]   in_priority_req,
  input  logic signed [spq_pkg::DATA_W-1:0]   in_payload,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic        [spq_pkg::STATUS_W-1:0] out_status,
  output logic        [spq_pkg::PRIO_W-1:0]   out_priority,
  output logic signed [spq_pkg::DATA_W-1:0]   out_payload
);

  spq_pkg::cmd_t  cmd;
  spq_pkg::stat_t stat;

  // Sequencing.
  spq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Storage, compare/shift and result register.
  spq_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_func         (in_func),
    .in_priority_req (in_priority_req),
    .in_payload      (in_payload),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_priority    (out_priority),
    .out_payload     (out_payload)
  );

endmodule
